FILE: rtl/fsa_pkg.sv
// Shared types and constants for the segment allocator.
// Used by fsa_cell, fit_strategy_segment_allocator_core and the testbench files; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fsa_pkg;

	localparam int MAX_SEGMENTS_DEF = 64;
	localparam int OFF_W  = 16;
	localparam int SIZE_W = 17;
	localparam logic [SIZE_W-1:0] POOL_MAX = 17'h10000;

	// fit strategies
	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;
	localparam logic [1:0] FIT_NEXT  = 2'd3;

	// request modes
	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOFIT    = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_BAD      = 3'd4;

	// register indexes
	localparam logic CFG_FIT  = 1'b0;
	localparam logic CFG_POOL = 1'b1;

	typedef struct packed {
		logic [OFF_W-1:0]  off;
		logic [SIZE_W-1:0] size;
		logic              used;
	} seg_t;

	// commands broadcast along the row of cells
	typedef enum logic [2:0] {
		OP_HOLD  = 3'd0,
		OP_ROT   = 3'd1,
		OP_WR    = 3'd2,
		OP_INS   = 3'd3,
		OP_MERGE = 3'd4,
		OP_INIT  = 3'd5
	} op_t;

	typedef struct packed {
		op_t  op;
		seg_t data;
	} cmd_t;

endpackage
`default_nettype wire

FILE: rtl/fsa_cell.sv
// One table entry of the segment allocator: holds a segment and moves it
// to or from its neighbors on broadcast commands. Depends on fsa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fsa_cell #(
	parameter int MAX_SEGMENTS = fsa_pkg::MAX_SEGMENTS_DEF,
	parameter int CELL_IDX = 0
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire fsa_pkg::cmd_t                   cmd,
	input  wire logic [$clog2(MAX_SEGMENTS)-1:0] idx,
	input  wire fsa_pkg::seg_t                   left,
	input  wire fsa_pkg::seg_t                   right,
	output fsa_pkg::seg_t                        seg_q
);
	import fsa_pkg::*;

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam logic [IW:0] ME = (IW+1)'(CELL_IDX);
	localparam bit IS_FIRST = (CELL_IDX == 0);
	localparam bit IS_LAST  = (CELL_IDX == MAX_SEGMENTS - 1);
	// entry zero starts as one free segment covering the whole pool
	localparam seg_t RST_SEG = '{off: '0, size: IS_FIRST ? POOL_MAX : '0, used: 1'b0};

	logic [IW:0] idx_w;
	assign idx_w = {1'b0, idx};

	// entry update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= RST_SEG;
		end else begin
			case (cmd.op)
				OP_ROT: seg_q <= right;
				OP_WR: begin
					if (ME == idx_w) seg_q <= cmd.data;
				end
				OP_INS: begin
					if (ME == idx_w) seg_q <= cmd.data;
					else if (ME > idx_w) seg_q <= left;
				end
				OP_MERGE: begin
					// absorb into idx-1, close the gap above
					if (ME + 1'b1 == idx_w) seg_q <= cmd.data;
					else if (ME >= idx_w) seg_q <= IS_LAST ? '0 : right;
				end
				OP_INIT: seg_q <= IS_FIRST ? cmd.data : '0;
				default: seg_q <= seg_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/fit_strategy_segment_allocator_core.sv
// Top level of the segment allocator: sequencer around a row of fsa_cell.
// Depends on fsa_pkg and fsa_cell.
`timescale 1ns / 1ps
`default_nettype none
// The segment table lives in a row of MAX_SEGMENTS cells that rotate as a
// ring, so every entry passes the head once per pass. Allocate and free run
// a search pass (S_SCAN), two update states (S_MOD1, S_MOD2), a statistics
// pass (S_STAT) and hand-off (S_OUT); query or a rejected request runs only
// the statistics pass and hand-off.
// One request is in the block at a time; in_stall is high until the result
// has been taken. A pool_bytes write re-initializes the table at once.
module fit_strategy_segment_allocator_core #(
	parameter int MAX_SEGMENTS = fsa_pkg::MAX_SEGMENTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [16:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [16:0] request_bytes,
	input  wire logic [15:0] block_offset,
	input  wire logic [16:0] small_limit,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [15:0]      alloc_offset,
	output logic [6:0]       hole_count,
	output logic [16:0]      free_total,
	output logic [16:0]      largest_hole,
	output logic [6:0]       small_hole_count
);
	import fsa_pkg::*;

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [IW-1:0] LAST_T = IW'(MAX_SEGMENTS - 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_MOD1 = 6'b000100,
		S_MOD2 = 6'b001000,
		S_STAT = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	logic [IW-1:0] t_q, cur_q;
	logic [CW-1:0] count_q;
	logic [1:0] strat_q, mode_q;
	logic [SIZE_W-1:0] req_q, lim_q;
	logic [OFF_W-1:0] off_q;

	// search results
	logic found_q, ge_found_q, lt_found_q;
	logic [IW-1:0] pick_q, ge_pick_q, lt_pick_q;
	logic [SIZE_W-1:0] psize_q, ge_size_q, lt_size_q;
	logic [OFF_W-1:0] poff_q, ge_off_q, lt_off_q;
	logic prev_used_q, lfree_q, rfree_q, split_q;
	logic [SIZE_W-1:0] prev_size_q, lsize_q, rsize_q, csize_q;
	logic [OFF_W-1:0] prev_off_q, loff_q, coff_q;
	logic [IW-1:0] cidx_q;

	// result registers
	logic out_valid_q;
	logic [2:0] status_q;
	logic [OFF_W-1:0] where_q;
	logic [CW-1:0] holes_q, small_q;
	logic [SIZE_W-1:0] total_q, big_q;

	cmd_t cmd;
	logic [IW-1:0] cmd_idx;
	seg_t seg_w [MAX_SEGMENTS];
	seg_t head;

	// row of cells, ring closed from cell 0 back to the last one
	for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
		fsa_cell #(.MAX_SEGMENTS(MAX_SEGMENTS), .CELL_IDX(k)) u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .idx(cmd_idx),
			.left(seg_w[(k + MAX_SEGMENTS - 1) % MAX_SEGMENTS]),
			.right(seg_w[(k + 1) % MAX_SEGMENTS]),
			.seg_q(seg_w[k])
		);
	end
	assign head = seg_w[0];

	logic in_acc, out_acc, in_rng, fits, t_last, hole_here;
	logic [IW-1:0] start;
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_rng = CW'(t_q) < count_q;
	assign fits = in_rng && !head.used && head.size >= req_q;
	assign hole_here = in_rng && !head.used;
	assign t_last = t_q == LAST_T;
	assign start = (CW'(cur_q) < count_q) ? cur_q : '0;

	// chosen segment for allocate
	logic a_found;
	logic [IW-1:0] a_pick;
	logic [SIZE_W-1:0] a_size;
	logic [OFF_W-1:0] a_off;
	always_comb begin
		a_found = found_q;
		a_pick = pick_q;
		a_size = psize_q;
		a_off = poff_q;
		if (strat_q == FIT_NEXT) begin
			a_found = ge_found_q || lt_found_q;
			a_pick = ge_found_q ? ge_pick_q : lt_pick_q;
			a_size = ge_found_q ? ge_size_q : lt_size_q;
			a_off = ge_found_q ? ge_off_q : lt_off_q;
		end
	end

	logic [SIZE_W-1:0] msize_l, msize_r;
	logic [IW-1:0] pick_p1, cidx_p1;
	assign msize_l = lsize_q + psize_q;
	assign msize_r = csize_q + rsize_q;
	assign pick_p1 = pick_q + 1'b1;
	assign cidx_p1 = cidx_q + 1'b1;

	// command to the cell row
	always_comb begin
		cmd.op = OP_HOLD;
		cmd.data = '0;
		cmd_idx = '0;
		if (cfg_valid && cfg_index == CFG_POOL) begin
			cmd.op = OP_INIT;
			cmd.data.size = (cfg_data > POOL_MAX) ? POOL_MAX : cfg_data;
		end else begin
			case (state_q)
				S_SCAN, S_STAT: cmd.op = OP_ROT;
				S_MOD1: begin
					if (mode_q == MODE_ALLOC) begin
						if (a_found && !(a_size > req_q && count_q >= MAX_CNT)) begin
							cmd.op = OP_WR;
							cmd_idx = a_pick;
							cmd.data = '{off: a_off,
								size: (a_size > req_q) ? req_q : a_size, used: 1'b1};
						end
					end else if (found_q) begin
						if (lfree_q) begin
							cmd.op = OP_MERGE;
							cmd_idx = pick_q;
							cmd.data = '{off: loff_q, size: msize_l, used: 1'b0};
						end else begin
							cmd.op = OP_WR;
							cmd_idx = pick_q;
							cmd.data = '{off: poff_q, size: psize_q, used: 1'b0};
						end
					end
				end
				S_MOD2: begin
					if (status_q == ST_OK) begin
						if (mode_q == MODE_ALLOC && split_q) begin
							cmd.op = OP_INS;
							cmd_idx = pick_p1;
							cmd.data = '{off: poff_q + req_q[OFF_W-1:0],
								size: psize_q - req_q, used: 1'b0};
						end else if (mode_q == MODE_FREE && rfree_q) begin
							cmd.op = OP_MERGE;
							cmd_idx = cidx_p1;
							cmd.data = '{off: coff_q, size: msize_r, used: 1'b0};
						end
					end
				end
				default: cmd.op = OP_HOLD;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			t_q <= '0;
			cur_q <= '0;
			count_q <= CW'(1);
			strat_q <= FIT_FIRST;
			out_valid_q <= 1'b0;
			status_q <= ST_OK;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_FIT) begin
					strat_q <= cfg_data[1:0];
				end else begin
					count_q <= CW'(1);
					cur_q <= '0;
				end
			end
			case (state_q)
				S_IDLE: begin
					t_q <= '0;
					if (in_acc) begin
						found_q <= 1'b0;
						ge_found_q <= 1'b0;
						lt_found_q <= 1'b0;
						lfree_q <= 1'b0;
						rfree_q <= 1'b0;
						split_q <= 1'b0;
						where_q <= '0;
						if ((mode == MODE_ALLOC && request_bytes != '0) || mode == MODE_FREE) begin
							status_q <= ST_OK;
							state_q <= S_SCAN;
						end else begin
							status_q <= (mode == MODE_QUERY) ? ST_OK : ST_BAD;
							state_q <= S_STAT;
						end
					end
				end
				S_SCAN: begin
					t_q <= t_q + 1'b1;
					prev_used_q <= head.used;
					prev_size_q <= head.size;
					prev_off_q <= head.off;
					if (mode_q == MODE_ALLOC) begin
						if (fits && (!found_q || (strat_q == FIT_BEST && head.size < psize_q)
								|| (strat_q == FIT_WORST && head.size > psize_q))) begin
							found_q <= 1'b1;
							pick_q <= t_q;
							psize_q <= head.size;
							poff_q <= head.off;
						end
						if (fits && !ge_found_q && t_q >= start) begin
							ge_found_q <= 1'b1;
							ge_pick_q <= t_q;
							ge_size_q <= head.size;
							ge_off_q <= head.off;
						end
						if (fits && !lt_found_q) begin
							lt_found_q <= 1'b1;
							lt_pick_q <= t_q;
							lt_size_q <= head.size;
							lt_off_q <= head.off;
						end
					end else begin
						if (in_rng && !found_q && head.off == off_q) begin
							found_q <= 1'b1;
							pick_q <= t_q;
							psize_q <= head.size;
							poff_q <= head.off;
							lfree_q <= (t_q != '0) && !prev_used_q;
							lsize_q <= prev_size_q;
							loff_q <= prev_off_q;
						end
						if (in_rng && found_q && t_q == pick_p1) begin
							rfree_q <= !head.used;
							rsize_q <= head.size;
						end
					end
					if (t_last) state_q <= S_MOD1;
				end
				S_MOD1: begin
					state_q <= S_MOD2;
					if (mode_q == MODE_ALLOC) begin
						pick_q <= a_pick;
						psize_q <= a_size;
						poff_q <= a_off;
						if (!a_found) status_q <= ST_NOFIT;
						else if (a_size > req_q && count_q >= MAX_CNT) status_q <= ST_FULL;
						else begin
							where_q <= a_off;
							if (a_size > req_q) begin
								split_q <= 1'b1;
								count_q <= count_q + 1'b1;
								cur_q <= a_pick + 1'b1;
							end else begin
								cur_q <= (CW'(a_pick) + 1'b1 < count_q) ? a_pick + 1'b1 : '0;
							end
						end
					end else if (!found_q) begin
						status_q <= ST_NOTFOUND;
					end else if (lfree_q) begin
						count_q <= count_q - 1'b1;
						if (cur_q >= pick_q) cur_q <= cur_q - 1'b1;
						cidx_q <= pick_q - 1'b1;
						csize_q <= msize_l;
						coff_q <= loff_q;
					end else begin
						cidx_q <= pick_q;
						csize_q <= psize_q;
						coff_q <= poff_q;
					end
				end
				S_MOD2: begin
					state_q <= S_STAT;
					t_q <= '0;
					if (status_q == ST_OK && mode_q == MODE_FREE && rfree_q) begin
						count_q <= count_q - 1'b1;
						if (cur_q >= cidx_p1) cur_q <= cur_q - 1'b1;
					end
				end
				S_STAT: begin
					t_q <= t_q + 1'b1;
					if (t_q == '0) begin
						holes_q <= hole_here ? CW'(1) : '0;
						small_q <= hole_here ? CW'(head.size <= lim_q) : '0;
						total_q <= hole_here ? head.size : '0;
						big_q <= hole_here ? head.size : '0;
					end else if (hole_here) begin
						holes_q <= holes_q + 1'b1;
						small_q <= small_q + CW'(head.size <= lim_q);
						total_q <= total_q + head.size;
						if (head.size > big_q) big_q <= head.size;
					end
					if (t_last) begin
						state_q <= S_OUT;
						out_valid_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request payload capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= mode;
			req_q <= request_bytes;
			off_q <= block_offset;
			lim_q <= small_limit;
		end
	end

	assign cfg_ready = 1'b1;
	assign in_stall = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign alloc_offset = where_q;
	assign hole_count = 7'(holes_q);
	assign free_total = total_q;
	assign largest_hole = big_q;
	assign small_hole_count = 7'(small_q);

	// checks
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT)
		else $error("result valid outside hand-off state");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= MAX_CNT)
		else $error("segment count out of range");
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("second request taken while busy");

endmodule
`default_nettype wire

FILE: tb/fsa_checker.sv
// Checker for the segment allocator: watches the request, result and register
// channels, predicts each result from its own copy of the segment table, compares.
// Depends on fsa_pkg.
`timescale 1ns / 1ps
module fsa_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [16:0] request_bytes,
	input  logic [15:0] block_offset,
	input  logic [16:0] small_limit,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [15:0] alloc_offset,
	input  logic [6:0]  hole_count,
	input  logic [16:0] free_total,
	input  logic [16:0] largest_hole,
	input  logic [6:0]  small_hole_count,
	output int          fail_count,
	output int          pending
);
	import fsa_pkg::*;

	localparam int NSEG = MAX_SEGMENTS_DEF;

	typedef struct packed {
		logic [2:0]  st;
		logic [15:0] off;
		logic [6:0]  holes;
		logic [16:0] total;
		logic [16:0] big;
		logic [6:0]  small_n;
	} alloc_result_t;

	// model of the segment table
	logic [15:0] tbl_off [NSEG];
	logic [16:0] tbl_size [NSEG];
	logic        tbl_used [NSEG];
	int          tbl_n;
	int          cursor;
	logic [1:0]  strategy;
	logic [16:0] pool_size;

	alloc_result_t expected_q[$];

	function automatic void table_reinit();
		for (int i = 0; i < NSEG; i++) begin
			tbl_off[i] = '0;
			tbl_size[i] = '0;
			tbl_used[i] = 1'b0;
		end
		tbl_size[0] = pool_size;
		tbl_n = 1;
		cursor = 0;
	endfunction

	function automatic void drop_entry(int idx);
		for (int k = idx; k + 1 < tbl_n; k++) begin
			tbl_off[k] = tbl_off[k+1];
			tbl_size[k] = tbl_size[k+1];
			tbl_used[k] = tbl_used[k+1];
		end
		tbl_n--;
		if (cursor == idx)
			cursor = idx - 1;
		else if (cursor > idx)
			cursor--;
	endfunction

	function automatic logic [2:0] model_alloc(logic [16:0] req, output logic [15:0] where);
		int pick;
		int start;
		int i;
		pick = tbl_n;
		where = '0;
		if (req == 0)
			return ST_BAD;
		if (strategy == FIT_NEXT) begin
			start = (cursor < tbl_n) ? cursor : 0;
			for (int k = 0; k < tbl_n; k++) begin
				i = (start + k) % tbl_n;
				if (!tbl_used[i] && tbl_size[i] >= req) begin
					pick = i;
					break;
				end
			end
		end else begin
			for (i = 0; i < tbl_n; i++) begin
				if (tbl_used[i] || tbl_size[i] < req)
					continue;
				if (pick == tbl_n) begin
					pick = i;
					if (strategy == FIT_FIRST)
						break;
				end else if (strategy == FIT_BEST && tbl_size[i] < tbl_size[pick]) begin
					pick = i;
				end else if (strategy == FIT_WORST && tbl_size[i] > tbl_size[pick]) begin
					pick = i;
				end
			end
		end
		if (pick == tbl_n)
			return ST_NOFIT;
		if (tbl_size[pick] > req) begin
			if (tbl_n >= NSEG)
				return ST_FULL;
			for (int k = tbl_n; k > pick + 1; k--) begin
				tbl_off[k] = tbl_off[k-1];
				tbl_size[k] = tbl_size[k-1];
				tbl_used[k] = tbl_used[k-1];
			end
			tbl_n++;
			tbl_off[pick+1] = tbl_off[pick] + req[15:0];
			tbl_size[pick+1] = tbl_size[pick] - req;
			tbl_used[pick+1] = 1'b0;
			tbl_size[pick] = req;
			cursor = pick + 1;
		end else begin
			cursor = (pick + 1 < tbl_n) ? pick + 1 : 0;
		end
		tbl_used[pick] = 1'b1;
		where = tbl_off[pick];
		return ST_OK;
	endfunction

	function automatic logic [2:0] model_free(logic [15:0] off);
		int i;
		for (i = 0; i < tbl_n; i++)
			if (tbl_off[i] == off)
				break;
		if (i == tbl_n)
			return ST_NOTFOUND;
		tbl_used[i] = 1'b0;
		if (i > 0 && !tbl_used[i-1]) begin
			tbl_size[i-1] = tbl_size[i-1] + tbl_size[i];
			drop_entry(i);
			i--;
		end
		if (i + 1 < tbl_n && !tbl_used[i+1]) begin
			tbl_size[i] = tbl_size[i] + tbl_size[i+1];
			drop_entry(i + 1);
		end
		return ST_OK;
	endfunction

	function automatic alloc_result_t predict_result(logic [1:0] md, logic [16:0] req,
			logic [15:0] off, logic [16:0] lim);
		alloc_result_t r;
		logic [15:0] where;
		logic [17:0] sum;
		r = '0;
		where = '0;
		sum = '0;
		case (md)
			MODE_ALLOC: r.st = model_alloc(req, where);
			MODE_FREE:  r.st = model_free(off);
			MODE_QUERY: r.st = ST_OK;
			default:    r.st = ST_BAD;
		endcase
		r.off = (r.st == ST_OK) ? where : '0;
		for (int i = 0; i < tbl_n; i++) begin
			if (tbl_used[i])
				continue;
			r.holes++;
			sum += tbl_size[i];
			if (tbl_size[i] > r.big)
				r.big = tbl_size[i];
			if (tbl_size[i] <= lim)
				r.small_n++;
		end
		r.total = sum[16:0];
		return r;
	endfunction

	// track register writes, predict on accepted requests, check accepted results
	always @(posedge clk or negedge arst_n) begin
		alloc_result_t exp_r;
		alloc_result_t got;
		if (!arst_n) begin
			strategy = FIT_FIRST;
			pool_size = POOL_MAX;
			table_reinit();
			expected_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_FIT) begin
					strategy = cfg_data[1:0];
				end else begin
					pool_size = (cfg_data > POOL_MAX) ? POOL_MAX : cfg_data;
					table_reinit();
				end
			end
			if (out_valid && !out_stall) begin
				got = '{status, alloc_offset, hole_count, free_total, largest_hole,
					small_hole_count};
				if (expected_q.size() == 0) begin
					$display("%0t: result with none expected, got %p", $time, got);
					fail_count++;
				end else begin
					exp_r = expected_q.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(predict_result(mode, request_bytes, block_offset,
					small_limit));
			pending = expected_q.size();
		end
	end
endmodule

FILE: tb/testbench.sv
// Top of the segment allocator testbench: clock, reset, register writes,
// request stimulus and verdict. Depends on fsa_pkg, fsa_checker and the core.
`timescale 1ns / 1ps
module testbench;
	import fsa_pkg::*;

	localparam int WATCHDOG = 20000;
	// mode code outside the defined set
	localparam logic [1:0] MODE_UNKNOWN = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_FIT;
	logic [16:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = MODE_QUERY;
	logic [16:0] request_bytes = '0;
	logic [15:0] block_offset = '0;
	logic [16:0] small_limit = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [15:0] alloc_offset;
	logic [6:0]  hole_count;
	logic [16:0] free_total;
	logic [16:0] largest_hole;
	logic [6:0]  small_hole_count;
	int          fail_count;
	int          pending;

	int  send_idle_pct = 25;
	int  recv_idle_pct = 80;
	bit  hold_recv = 1'b0;
	int  idle_cycles = 0;
	logic [15:0] taken_offs[$];

	always #1 clk = ~clk;

	fit_strategy_segment_allocator_core dut (.*);

	fsa_checker checker_i (.*);

	// result side: random stall, or a long hold when asked
	always @(posedge clk) begin
		if (hold_recv)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// remember offsets handed out, to aim frees at real segments
	always @(posedge clk) begin
		if (out_valid && !out_stall && status == ST_OK && alloc_offset != 0)
			taken_offs.push_back(alloc_offset);
		if (taken_offs.size() > 80)
			void'(taken_offs.pop_front());
	end

	// watchdog on cycles with no accepted transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic idx, logic [16:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// valid stays up after the handshake; the next request, an idle cycle
	// or drain() takes it down
	task automatic send_request(logic [1:0] md, logic [16:0] req, logic [15:0] off,
			logic [16:0] lim);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		request_bytes <= req;
		block_offset <= off;
		small_limit <= lim;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || in_stall)
			@(posedge clk);
		repeat (2 * MAX_SEGMENTS_DEF + 10) @(posedge clk);
	endtask

	task automatic random_request(int pool);
		int r;
		logic [16:0] req;
		logic [15:0] off;
		r = $urandom_range(99);
		if (r < 45)
			req = ($urandom_range(3) == 0) ? 17'($urandom_range(pool + 2))
				: 17'($urandom_range(1, pool / 16 + 1));
		else
			req = 17'($urandom);
		if (taken_offs.size() > 0 && $urandom_range(9) < 8)
			off = taken_offs[$urandom_range(taken_offs.size() - 1)];
		else
			off = 16'($urandom);
		if (r < 45)
			send_request(MODE_ALLOC, req, off, 17'($urandom_range(pool)));
		else if (r < 88)
			send_request(MODE_FREE, req, off, 17'($urandom_range(pool)));
		else if (r < 97)
			send_request(MODE_QUERY, req, off, 17'($urandom));
		else
			send_request(MODE_UNKNOWN, req, off, 17'($urandom));
	endtask

	initial begin
		int pools[6] = '{65536, 1000, 64, 0, 1, 300};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes and special cases at reset settings
		send_idle_pct = 0;
		send_request(MODE_QUERY, 17'h1FFFF, 16'hFFFF, 17'h1FFFF);
		send_request(MODE_ALLOC, 17'd0, 16'd0, 17'd0);
		send_request(MODE_UNKNOWN, 17'd5, 16'd0, 17'd0);
		send_request(MODE_ALLOC, 17'h1FFFF, 16'd0, 17'd0);
		send_request(MODE_ALLOC, 17'd100, 16'd0, 17'd200);
		send_request(MODE_ALLOC, 17'd200, 16'd0, 17'h1FFFF);
		send_request(MODE_FREE, 17'd0, 16'd7, 17'd0);
		send_request(MODE_FREE, 17'd0, 16'd0, 17'd100);
		send_request(MODE_FREE, 17'd0, 16'd0, 17'd100);
		send_request(MODE_FREE, 17'd0, 16'd100, 17'h10000);
		send_request(MODE_ALLOC, 17'h10000, 16'd0, 17'h10000);
		send_request(MODE_FREE, 17'd0, 16'd0, 17'd0);
		drain();
		// table full: 65 single-byte allocations (63 fit before the table is full), then an exact 7-byte fit
		write_reg(CFG_POOL, 17'd70);
		for (int i = 0; i < 65; i++)
			send_request(MODE_ALLOC, 17'd1, 16'd0, 17'd1);
		send_request(MODE_ALLOC, 17'd7, 16'd0, 17'd7);
		drain();
		write_reg(CFG_POOL, 17'h1FFFF);
		send_request(MODE_QUERY, 17'd0, 16'd0, 17'h10000);

		// long receiver hold while requests keep coming
		fork
			begin
				hold_recv = 1'b1;
				repeat (600) @(posedge clk);
				hold_recv = 1'b0;
			end
			for (int i = 0; i < 6; i++)
				send_request(MODE_ALLOC, 17'd16, 16'd0, 17'd64);
		join
		drain();

		// random phases across strategies, pool sizes and idle patterns
		for (int ph = 0; ph < 24; ph++) begin
			int pool;
			if (ph == 0) begin
				send_idle_pct = 25;
				recv_idle_pct = 80;
			end else if (ph == 8) begin
				send_idle_pct = 80;
				recv_idle_pct = 25;
			end else if (ph == 16) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			pool = pools[ph % 6];
			write_reg(CFG_FIT, 2'(ph % 4));
			write_reg(CFG_POOL, 17'(pool));
			taken_offs.delete();
			for (int i = 0; i < 80; i++)
				random_request(pool);
			drain();
		end

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
